// ===== rtl/assert_macros.svh =====
// Assertion macros shared by the RTL of the level-order tree table.
// Needs a clock named clock and an active-high reset named reset in scope.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Implication or plain property checked on every rising clock edge outside reset
`define ASSERT_CLK(label, prop, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (prop)) else $error(msg);

// Property that must never hold on a rising clock edge outside reset
`define ASSERT_NEVER(label, expr, msg) \
   label: assert property (@(posedge clock) disable iff (reset) !(expr)) else $error(msg);

`endif

// ===== rtl/lott_pkg.sv =====
// Constants and codes for the level-order complete tree table.
// No dependencies; imported by the core, tree_table_checker and tb.
`timescale 1ns / 1ps

package lott_pkg;

   // Table size and derived widths
   localparam int CAPACITY = 32;
   localparam int ADDR_W   = $clog2(CAPACITY);
   localparam int CNT_W    = $clog2(CAPACITY + 1);
   localparam int DATA_W   = 32;
   localparam int POS_W    = 6;

   // Request codes
   localparam logic [1:0] REQ_INSERT = 2'd0;
   localparam logic [1:0] REQ_DELETE = 2'd1;
   localparam logic [1:0] REQ_LIST   = 2'd2;
   localparam logic [1:0] REQ_SEARCH = 2'd3;

   // Status codes
   localparam logic [1:0] STAT_OK        = 2'd0;
   localparam logic [1:0] STAT_EMPTY     = 2'd1;
   localparam logic [1:0] STAT_NOT_FOUND = 2'd2;
   localparam logic [1:0] STAT_FULL      = 2'd3;

endpackage

// ===== rtl/level_order_complete_tree_table_core.sv =====
// Level-order table of a complete binary tree: insert, delete, list, search.
// Uses lott_pkg for sizes and codes, assert_macros.svh for the checks.
`timescale 1ns / 1ps
//
// Usage
//   A transaction is taken on a rising edge with start high and busy low;
//   req_type selects insert, delete, list or search, req_value is the key.
//   Results leave on the rsp_ ports for one cycle, flagged by rsp_valid;
//   rsp_last marks the final result of a transaction. The receiver cannot
//   stall, so every result is consumed in the cycle it is shown.
// Timing
//   Insert and every empty-table or full-table answer finish in the accept
//   cycle: the result is registered and appears in the next cycle, and busy
//   never rises, so a new transaction can follow at once.
//   Search, list and delete walk the table through a memory with one read
//   port, one read a cycle, from slot 0 up to the match (up to the count for
//   list or a miss); busy stays high during the walk. Delete then fetches
//   the last entry and adds a move step (S_MOVE) that writes it over the
//   match, unless the match is the last slot. List gives one result per
//   cycle.
// Reset
//   Reset empties the table (count to zero); the memory is not cleared, as
//   only slots below the count are ever read.

module level_order_complete_tree_table_core
   import lott_pkg::*;
(
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     start,
   output logic                     busy,
   input  logic [1:0]               req_type,
   input  logic signed [DATA_W-1:0] req_value,
   output logic                     rsp_valid,
   output logic [1:0]               rsp_status,
   output logic [POS_W-1:0]         rsp_position,
   output logic signed [DATA_W-1:0] rsp_element,
   output logic                     rsp_last
);

`include "assert_macros.svh"

   typedef enum logic [1:0] {
      S_IDLE,
      S_SCAN,
      S_MOVE
   } state_type;

   state_type            state_ff, state_in;
   logic [1:0]           op_ff, op_in;
   logic [DATA_W-1:0]    key_ff, key_in;
   logic [ADDR_W-1:0]    idx_ff, idx_in;
   logic [CNT_W-1:0]     count_ff, count_in;
   logic                 rsp_valid_ff, rsp_valid_in;
   logic [1:0]           status_ff, status_in;
   logic [POS_W-1:0]     pos_ff, pos_in;
   logic [DATA_W-1:0]    elem_ff, elem_in;
   logic                 last_ff, last_in;

   // Table memory, one read port with registered data, one write port
   logic [DATA_W-1:0]    mem [CAPACITY];
   logic [DATA_W-1:0]    rd_data_ff;
   logic                 rd_en;
   logic [ADDR_W-1:0]    rd_addr;
   logic                 wr_en;
   logic [ADDR_W-1:0]    wr_addr;
   logic [DATA_W-1:0]    wr_data;

   logic [CNT_W-1:0]     idx_inc;
   logic                 at_end;
   logic                 hit;

   assign idx_inc = CNT_W'(idx_ff) + CNT_W'(1);
   assign at_end  = (idx_inc == count_ff);
   assign hit     = (rd_data_ff == key_ff);

   // Next-state and memory access control
   always_comb begin
      state_in     = state_ff;
      op_in        = op_ff;
      key_in       = key_ff;
      idx_in       = idx_ff;
      count_in     = count_ff;
      rsp_valid_in = 1'b0;
      status_in    = STAT_OK;
      pos_in       = '0;
      elem_in      = '0;
      last_in      = 1'b1;
      rd_en        = 1'b0;
      rd_addr      = ADDR_W'(idx_inc);
      wr_en        = 1'b0;
      wr_addr      = idx_ff;
      wr_data      = rd_data_ff;

      case (state_ff)
         S_IDLE: begin
            if (start) begin
               op_in  = req_type;
               key_in = req_value;
               if (req_type == REQ_INSERT) begin
                  rsp_valid_in = 1'b1;
                  if (count_ff == CNT_W'(CAPACITY)) begin
                     status_in = STAT_FULL;
                  end else begin
                     wr_en    = 1'b1;
                     wr_addr  = ADDR_W'(count_ff);
                     wr_data  = req_value;
                     count_in = count_ff + CNT_W'(1);
                  end
               end else if (count_ff == '0) begin
                  rsp_valid_in = 1'b1;
                  status_in    = STAT_EMPTY;
               end else begin
                  // start the walk at the root slot
                  rd_en    = 1'b1;
                  rd_addr  = '0;
                  idx_in   = '0;
                  state_in = S_SCAN;
               end
            end
         end

         S_SCAN: begin
            // read data belongs to slot idx_ff; prefetch the next slot
            rd_en  = 1'b1;
            idx_in = ADDR_W'(idx_inc);
            case (op_ff) inside
               REQ_LIST: begin
                  rsp_valid_in = 1'b1;
                  elem_in      = rd_data_ff;
                  last_in      = at_end;
                  if (at_end) begin
                     state_in = S_IDLE;
                  end
               end
               REQ_SEARCH, REQ_DELETE: begin
                  if (hit) begin
                     if (op_ff == REQ_SEARCH) begin
                        rsp_valid_in = 1'b1;
                        pos_in       = POS_W'(idx_inc);
                        elem_in      = rd_data_ff;
                        state_in     = S_IDLE;
                     end else if (at_end) begin
                        // match in the last slot: just drop it
                        rsp_valid_in = 1'b1;
                        count_in     = count_ff - CNT_W'(1);
                        state_in     = S_IDLE;
                     end else begin
                        // fetch the last entry to move over the match
                        rd_addr  = ADDR_W'(count_ff - CNT_W'(1));
                        idx_in   = idx_ff;
                        state_in = S_MOVE;
                     end
                  end else if (at_end) begin
                     rsp_valid_in = 1'b1;
                     status_in    = STAT_NOT_FOUND;
                     state_in     = S_IDLE;
                  end
               end
               default: begin
                  state_in = S_IDLE;
               end
            endcase
         end

         S_MOVE: begin
            // last entry overwrites the matched slot
            wr_en        = 1'b1;
            wr_addr      = idx_ff;
            wr_data      = rd_data_ff;
            count_in     = count_ff - CNT_W'(1);
            rsp_valid_in = 1'b1;
            state_in     = S_IDLE;
         end

         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   // State and registered outputs
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      op_ff     <= op_in;
      key_ff    <= key_in;
      idx_ff    <= idx_in;
      status_ff <= status_in;
      pos_ff    <= pos_in;
      elem_ff   <= elem_in;
      last_ff   <= last_in;
   end

   // Memory: reads and writes never target the same slot in one cycle
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign busy         = (state_ff != S_IDLE);
   assign rsp_valid    = rsp_valid_ff;
   assign rsp_status   = status_ff;
   assign rsp_position = pos_ff;
   assign rsp_element  = elem_ff;
   assign rsp_last     = last_ff;

   // Checks
   `ASSERT_NEVER(a_count_range, count_ff > CNT_W'(CAPACITY), "entry count beyond capacity")
   `ASSERT_CLK(a_err_is_last, rsp_valid && (rsp_status != STAT_OK) |-> rsp_last,
               "error status without last flag")
   `ASSERT_CLK(a_insert_grows, start && !busy && (req_type == REQ_INSERT)
               && (count_ff != CNT_W'(CAPACITY)) |=> count_ff == $past(count_ff) + CNT_W'(1),
               "accepted insert did not grow the table")
   `ASSERT_CLK(a_write_state, wr_en |-> (state_ff == S_IDLE) || (state_ff == S_MOVE),
               "memory written during a scan")

endmodule

// ===== tb/tree_table_checker.sv =====
// Checker for the level-order tree table: mirrors the table, predicts every
// answer of each accepted transaction and compares the rsp_ channel with it.
// Depends on lott_pkg for sizes and codes.
`timescale 1ns / 1ps

module tree_table_checker
   import lott_pkg::*;
(
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     start,
   input  logic                     busy,
   input  logic [1:0]               req_type,
   input  logic signed [DATA_W-1:0] req_value,
   input  logic                     rsp_valid,
   input  logic [1:0]               rsp_status,
   input  logic [POS_W-1:0]         rsp_position,
   input  logic signed [DATA_W-1:0] rsp_element,
   input  logic                     rsp_last,
   output int                       mismatch_total,
   output int                       results_outstanding
);

   typedef struct packed {
      logic [1:0]        status;
      logic [POS_W-1:0]  position;
      logic [DATA_W-1:0] element;
      logic              last;
   } tree_answer_type;

   // Mirror of the table and the answers still owed by the block
   logic [DATA_W-1:0] slot_value [CAPACITY];
   int                slot_count;
   tree_answer_type   answers_due [$];

   function automatic void owe_answer(input logic [1:0] status, input int pos,
                                      input logic [DATA_W-1:0] elem, input logic fin);
      tree_answer_type a;
      a.status   = status;
      a.position = pos[POS_W-1:0];
      a.element  = elem;
      a.last     = fin;
      answers_due.push_back(a);
   endfunction

   // Apply one transaction to the mirror and queue the answers it causes
   function automatic void apply_tree_request(input logic [1:0] kind,
                                              input logic [DATA_W-1:0] key);
      int hit;
      int i;
      hit = -1;
      if (kind == REQ_INSERT) begin
         if (slot_count >= CAPACITY) begin
            owe_answer(STAT_FULL, 0, '0, 1'b1);
         end else begin
            slot_value[slot_count] = key;
            slot_count++;
            owe_answer(STAT_OK, 0, '0, 1'b1);
         end
      end else if (slot_count == 0) begin
         owe_answer(STAT_EMPTY, 0, '0, 1'b1);
      end else if (kind == REQ_LIST) begin
         for (i = 0; i < slot_count; i++)
            owe_answer(STAT_OK, 0, slot_value[i], i == slot_count - 1);
      end else begin
         // first match in level order only
         for (i = 0; i < slot_count; i++)
            if (hit < 0 && slot_value[i] == key) hit = i;
         if (hit < 0) begin
            owe_answer(STAT_NOT_FOUND, 0, '0, 1'b1);
         end else if (kind == REQ_DELETE) begin
            // last entry moves into the hole
            slot_value[hit] = slot_value[slot_count - 1];
            slot_count--;
            owe_answer(STAT_OK, 0, '0, 1'b1);
         end else begin
            owe_answer(STAT_OK, hit + 1, slot_value[hit], 1'b1);
         end
      end
   endfunction

   // Results are checked before the new transaction is predicted: an answer
   // seen on this edge always belongs to an earlier transaction
   always @(posedge clock) begin
      tree_answer_type want;
      if (reset) begin
         slot_count = 0;
         answers_due.delete();
      end else begin
         if (rsp_valid) begin
            if (answers_due.size() == 0) begin
               $error("unexpected result: status %0d position %0d element %0d last %0d",
                      rsp_status, rsp_position, rsp_element, rsp_last);
               mismatch_total++;
            end else begin
               want = answers_due.pop_front();
               if (rsp_status !== want.status) begin
                  $error("rsp_status: expected %0d, got %0d", want.status, rsp_status);
                  mismatch_total++;
               end
               if (rsp_position !== want.position) begin
                  $error("rsp_position: expected %0d, got %0d",
                         want.position, rsp_position);
                  mismatch_total++;
               end
               if (rsp_element !== want.element) begin
                  $error("rsp_element: expected %0d, got %0d",
                         $signed(want.element), rsp_element);
                  mismatch_total++;
               end
               if (rsp_last !== want.last) begin
                  $error("rsp_last: expected %0d, got %0d", want.last, rsp_last);
                  mismatch_total++;
               end
            end
         end
         if (start && !busy)
            apply_tree_request(req_type, req_value);
      end
      results_outstanding = answers_due.size();
   end

endmodule

// ===== tb/tb.sv =====
// Top of the tree table testbench: clock, reset, transaction stimulus,
// watchdog and verdict. Depends on lott_pkg, tree_table_checker and the core.
`timescale 1ns / 1ps

module tb;
   import lott_pkg::*;

   localparam int STALL_LIMIT = 2000;
   localparam int KEY_POOL_N  = 10;

   logic                     clock;
   logic                     reset;
   logic                     start;
   logic                     busy;
   logic [1:0]               req_type;
   logic signed [DATA_W-1:0] req_value;
   logic                     rsp_valid;
   logic [1:0]               rsp_status;
   logic [POS_W-1:0]         rsp_position;
   logic signed [DATA_W-1:0] rsp_element;
   logic                     rsp_last;
   int                       mismatch_total;
   int                       results_outstanding;

   int                idle_pct;
   int                stall_cycles;
   logic [DATA_W-1:0] key_pool [KEY_POOL_N];

   level_order_complete_tree_table_core u_dut (
      .clock        (clock),
      .reset        (reset),
      .start        (start),
      .busy         (busy),
      .req_type     (req_type),
      .req_value    (req_value),
      .rsp_valid    (rsp_valid),
      .rsp_status   (rsp_status),
      .rsp_position (rsp_position),
      .rsp_element  (rsp_element),
      .rsp_last     (rsp_last)
   );

   tree_table_checker u_checker (
      .clock               (clock),
      .reset               (reset),
      .start               (start),
      .busy                (busy),
      .req_type            (req_type),
      .req_value           (req_value),
      .rsp_valid           (rsp_valid),
      .rsp_status          (rsp_status),
      .rsp_position        (rsp_position),
      .rsp_element         (rsp_element),
      .rsp_last            (rsp_last),
      .mismatch_total      (mismatch_total),
      .results_outstanding (results_outstanding)
   );

   initial begin
      clock = 1'b0;
      forever #4 clock = ~clock;
   end

   // Watchdog: too long without any transaction or result moving
   always @(posedge clock) begin
      if (reset || (start && !busy) || rsp_valid) begin
         stall_cycles <= 0;
      end else begin
         stall_cycles <= stall_cycles + 1;
         if (stall_cycles >= STALL_LIMIT) begin
            $display("tb: done, errors");
            $finish;
         end
      end
   end

   // Issue one transaction, with a random gap first, and wait for it to go in.
   // busy is looked at mid-cycle, so the edge that takes the transaction is
   // known; start stays high into the next transaction when no gap is drawn.
   task automatic send_request(input logic [1:0] kind, input logic [DATA_W-1:0] key);
      if ($urandom_range(99) < idle_pct) begin
         start <= 1'b0;
         @(posedge clock);
         while ($urandom_range(99) < idle_pct) @(posedge clock);
      end
      start     <= 1'b1;
      req_type  <= kind;
      req_value <= key;
      @(negedge clock);
      while (busy) @(negedge clock);
      @(posedge clock);
   endtask

   // Keys mostly from a small pool so that deletes and searches hit
   function automatic logic [DATA_W-1:0] pick_key();
      if ($urandom_range(99) < 60) return key_pool[$urandom_range(KEY_POOL_N - 1)];
      return $urandom();
   endfunction

   function automatic logic [1:0] pick_request();
      int r;
      r = $urandom_range(99);
      if (r < 30) return REQ_INSERT;
      if (r < 65) return REQ_DELETE;
      if (r < 90) return REQ_SEARCH;
      return REQ_LIST;
   endfunction

   initial begin
      int idle_plan [4];
      int p;
      int n;
      idle_plan    = '{0, 51, 0, 24};
      idle_pct     = 0;
      reset        <= 1'b1;
      start        <= 1'b0;
      req_type     <= REQ_INSERT;
      req_value    <= '0;
      key_pool[0]  = 32'h7fff_ffff;
      key_pool[1]  = 32'h8000_0000;
      key_pool[2]  = 32'h0000_0000;
      key_pool[3]  = 32'hffff_ffff;
      for (n = 4; n < KEY_POOL_N; n++) key_pool[n] = $urandom();
      repeat (4) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Directed: empty table, extremes, duplicates, misses, delete of last slot
      send_request(REQ_LIST,   32'd0);
      send_request(REQ_DELETE, 32'd5);
      send_request(REQ_SEARCH, 32'd5);
      send_request(REQ_INSERT, 32'h7fff_ffff);
      send_request(REQ_INSERT, 32'h8000_0000);
      send_request(REQ_INSERT, 32'h0000_0000);
      send_request(REQ_INSERT, 32'hffff_ffff);
      send_request(REQ_INSERT, 32'h0000_0000);
      send_request(REQ_SEARCH, 32'h0000_0000);
      send_request(REQ_SEARCH, 32'h8000_0000);
      send_request(REQ_SEARCH, 32'd12345);
      send_request(REQ_DELETE, 32'd12345);
      send_request(REQ_LIST,   32'd0);
      send_request(REQ_DELETE, 32'h0000_0000);
      send_request(REQ_DELETE, 32'hffff_ffff);
      send_request(REQ_DELETE, 32'h7fff_ffff);
      send_request(REQ_LIST,   32'd0);
      send_request(REQ_SEARCH, 32'h8000_0000);
      send_request(REQ_DELETE, 32'h0000_0000);
      send_request(REQ_DELETE, 32'h8000_0000);
      send_request(REQ_LIST,   32'd0);
      send_request(REQ_INSERT, 32'h5555_5555);
      send_request(REQ_INSERT, 32'haaaa_aaaa);
      send_request(REQ_SEARCH, 32'haaaa_aaaa);
      send_request(REQ_DELETE, 32'h5555_5555);

      // Random phases: fill past full, list the full table, then mixed traffic
      for (p = 0; p < 4; p++) begin
         idle_pct = idle_plan[p];
         for (n = 0; n < CAPACITY + 2; n++) send_request(REQ_INSERT, pick_key());
         send_request(REQ_LIST, pick_key());
         for (n = 0; n < 65; n++) send_request(pick_request(), pick_key());
      end

      // Drain and let any stray result show up
      start <= 1'b0;
      @(posedge clock);
      while (results_outstanding != 0) @(posedge clock);
      repeat (CAPACITY + 8) @(posedge clock);
      if (mismatch_total == 0) begin
         $display("tb: done, clean");
      end else begin
         $display("tb: done, errors");
      end
      $finish;
   end

endmodule
